[src/esc_pkg.sv]
// Shared constants and tables for the exposure setting calculator.
// No dependencies; used by esc_log2 and exposure_setting_calculator_core.
`default_nettype none
package esc_pkg;

  // Lux word width after correction, log unit latency
  localparam int LuxW   = 34;
  localparam int LogLat = 14;

  // Table sizes
  localparam int NumAp   = 38;
  localparam int NumSh   = 14;
  localparam int NumIso  = 17;
  localparam int NumComp = 13;

  // Register addresses (word index)
  localparam logic [2:0] RegMode = 3'd0;
  localparam logic [2:0] RegSh   = 3'd1;
  localparam logic [2:0] RegAp   = 3'd2;
  localparam logic [2:0] RegIso  = 3'd3;
  localparam logic [2:0] RegComp = 3'd4;

  // Correction knee in Q4 lux, Q20 polynomial coefficients
  localparam logic [20:0] KneeQ4 = 21'd16000;
  localparam logic signed [50:0] PolyCoef [4] = '{
    51'sd693309, -51'sd10574902, 51'sd89597004, 51'sd1076211430};

  localparam logic signed [19:0] EvOffsetQ12 = 20'sd25895;

  localparam logic signed [15:0] IsoLg12 [NumIso] = '{
    -16'sd16625, -16'sd12529, -16'sd8192, -16'sd4096, -16'sd2637, 16'sd0,
    16'sd1319, 16'sd2777, 16'sd4096, 16'sd5415, 16'sd6873, 16'sd8192,
    16'sd9511, 16'sd12288, 16'sd16384, 16'sd20480, 16'sd24576};

  localparam logic signed [15:0] CompLg12 [NumComp] = '{
    -16'sd8192, -16'sd6963, -16'sd5325, -16'sd4096, -16'sd2867, -16'sd1229,
    16'sd0, 16'sd1229, 16'sd2867, 16'sd4096, 16'sd5325, 16'sd6963, 16'sd8192};

  localparam logic signed [15:0] ShutLg8 [NumSh] = '{
    -16'sd3063, -16'sd2807, -16'sd2551, -16'sd2295, -16'sd2039, -16'sd1783,
    -16'sd1511, -16'sd1257, -16'sd1000, -16'sd768, -16'sd512, -16'sd256,
    16'sd0, 16'sd256};

  localparam logic signed [15:0] ShutMid8 [NumSh-1] = '{
    -16'sd2913, -16'sd2657, -16'sd2401, -16'sd2145, -16'sd1889, -16'sd1623,
    -16'sd1362, -16'sd1106, -16'sd866, -16'sd618, -16'sd362, -16'sd106,
    16'sd150};

  localparam logic signed [15:0] FnumSq8 [NumAp] = '{
    -16'sd78, 16'sd0, 16'sd70, 16'sd135, 16'sd249, 16'sd392, 16'sd434,
    16'sd512, 16'sd647, 16'sd761, 16'sd812, 16'sd859, 16'sd925, 16'sd1024,
    16'sd1111, 16'sd1273, 16'sd1324, 16'sd1360, 16'sd1448, 16'sd1536,
    16'sd1623, 16'sd1701, 16'sd1771, 16'sd1895, 16'sd2048, 16'sd2135,
    16'sd2213, 16'sd2283, 16'sd2407, 16'sd2461, 16'sd2560, 16'sd2647,
    16'sd2725, 16'sd2812, 16'sd2919, 16'sd2919, 16'sd2973, 16'sd3072};

  localparam logic signed [15:0] FnumMid8 [NumAp-1] = '{
    -16'sd38, 16'sd36, 16'sd103, 16'sd194, 16'sd324, 16'sd413, 16'sd474,
    16'sd582, 16'sd706, 16'sd786, 16'sd836, 16'sd893, 16'sd976, 16'sd1069,
    16'sd1196, 16'sd1298, 16'sd1342, 16'sd1405, 16'sd1493, 16'sd1581,
    16'sd1663, 16'sd1737, 16'sd1836, 16'sd1975, 16'sd2093, 16'sd2175,
    16'sd2249, 16'sd2348, 16'sd2435, 16'sd2512, 16'sd2605, 16'sd2687,
    16'sd2770, 16'sd2867, 16'sd2947, 16'sd2947, 16'sd3024};

endpackage
`default_nettype wire

[src/esc_log2.sv]
// Pipelined log2 in Q12: leading-one detect, normalize, twelve squaring stages.
// Depends on esc_pkg. Advances on en.
`default_nettype none
module esc_log2 (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [esc_pkg::LuxW-1:0] x,
  output logic [5:0]                  e,
  output logic [11:0]                 frac
);
  import esc_pkg::*;

  logic [LuxW-1:0] x1;
  logic [5:0]      e1;
  logic [5:0]      e_det;
  logic [15:0]     m2;
  logic [5:0]      e2;
  logic [15:0]     m_q [13];
  logic [11:0]     f_q [13];
  logic [5:0]      e_q [13];

  // Leading-one position
  always_comb begin
    e_det = '0;
    for (int i = 0; i < LuxW; i++) begin
      if (x[i]) e_det = 6'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= x;
      e1 <= e_det;
      e2 <= e1;
      if (e1 >= 6'd15) m2 <= 16'(x1 >> (e1 - 6'd15));
      else m2 <= 16'(x1 << (6'd15 - e1));
    end
  end

  assign m_q[0] = m2;
  assign f_q[0] = '0;
  assign e_q[0] = e2;

  // One fraction bit per stage by squaring
  for (genvar k = 0; k < 12; k++) begin : g_sq
    logic [31:0] p;
    logic [16:0] t;
    assign p = m_q[k] * m_q[k];
    assign t = p[31:15];
    always_ff @(posedge clk) begin
      if (en) begin
        m_q[k+1] <= t[16] ? t[16:1] : t[15:0];
        f_q[k+1] <= {f_q[k][10:0], t[16]};
        e_q[k+1] <= e_q[k];
      end
    end
  end

  assign e    = e_q[12];
  assign frac = f_q[12];

endmodule
`default_nettype wire

[src/exposure_setting_calculator_core.sv]
// Exposure setting calculator top level: correction, log2, EV and selection.
// Depends on esc_pkg and esc_log2.
//
// One lux word enters per cycle while the output is not stalled; the depth
// is set by the four multiply steps and three add steps of the quartic
// correction and the fourteen stages of the log2 unit. The whole
// pipeline holds when the output word is not taken, so input ready follows
// output ready. Configuration is live and should be written only while the
// pipeline is empty.
`default_nettype none
module exposure_setting_calculator_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [20:0] lux_sample
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [15:0] ev_value, [21:16] aperture_index,
                                      // [25:22] shutter_index
  output logic             m_tuser,   // [0] ev_saturated
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import esc_pkg::*;

  logic       cfg_mode;
  logic [3:0] cfg_sh;
  logic [5:0] cfg_ap;
  logic [4:0] cfg_iso;
  logic [3:0] cfg_comp;
  logic       adv;

  // Register port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_mode <= 1'b0;
      cfg_sh   <= 4'd8;
      cfg_ap   <= 6'd6;
      cfg_iso  <= 5'd5;
      cfg_comp <= 4'd6;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        RegMode: cfg_mode <= pwdata[0];
        RegSh:   cfg_sh   <= pwdata[3:0];
        RegAp:   cfg_ap   <= pwdata[5:0];
        RegIso:  cfg_iso  <= pwdata[4:0];
        RegComp: cfg_comp <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      RegMode: prdata = {31'd0, cfg_mode};
      RegSh:   prdata = {28'd0, cfg_sh};
      RegAp:   prdata = {26'd0, cfg_ap};
      RegIso:  prdata = {27'd0, cfg_iso};
      RegComp: prdata = {28'd0, cfg_comp};
      default: prdata = '0;
    endcase
  end

  // Clamped indices
  logic [3:0] sh_c;
  logic [5:0] ap_c;
  logic [4:0] iso_c;
  logic [3:0] comp_c;
  assign sh_c   = (cfg_sh > 4'(NumSh - 1)) ? 4'(NumSh - 1) : cfg_sh;
  assign ap_c   = (cfg_ap > 6'(NumAp - 1)) ? 6'(NumAp - 1) : cfg_ap;
  assign iso_c  = (cfg_iso > 5'(NumIso - 1)) ? 5'(NumIso - 1) : cfg_iso;
  assign comp_c = (cfg_comp > 4'(NumComp - 1)) ? 4'(NumComp - 1) : cfg_comp;

  // Pipeline holds only when the output word is stalled
  logic o_v;
  assign adv      = !o_v || m_tready;
  assign s_tready = adv;

  // Input stage
  logic        s0_v;
  logic [20:0] s0_s;
  logic        s0_big;
  always_ff @(posedge clk) begin
    if (rst) s0_v <= 1'b0;
    else if (adv) s0_v <= s_tvalid;
    if (adv) begin
      s0_s   <= s_tdata[20:0];
      s0_big <= s_tdata[20:0] > KneeQ4;
    end
  end

  // Horner correction: multiply stage then sign/add stage per step; the last step has no add stage
  logic        pm_v   [4];
  logic [48:0] pm_q   [4];
  logic        pm_neg [4];
  logic [20:0] pm_s   [4];
  logic        pm_big [4];
  logic        pa_v   [3];
  logic [41:0] pa_mag [3];
  logic        pa_neg [3];
  logic [20:0] pa_s   [3];
  logic        pa_big [3];

  for (genvar k = 0; k < 4; k++) begin : g_mul
    logic        in_v, in_neg, in_big;
    logic [41:0] in_mag;
    logic [20:0] in_s;
    logic [62:0] prod;
    if (k == 0) begin : g_first
      assign in_v   = s0_v;
      assign in_mag = 42'(PolyCoef[0]);
      assign in_neg = 1'b0;
      assign in_s   = s0_s;
      assign in_big = s0_big;
    end else begin : g_next
      assign in_v   = pa_v[k-1];
      assign in_mag = pa_mag[k-1];
      assign in_neg = pa_neg[k-1];
      assign in_s   = pa_s[k-1];
      assign in_big = pa_big[k-1];
    end
    assign prod = in_mag * in_s;
    always_ff @(posedge clk) begin
      if (rst) pm_v[k] <= 1'b0;
      else if (adv) pm_v[k] <= in_v;
      if (adv) begin
        pm_q[k]   <= prod[62:14];
        pm_neg[k] <= in_neg;
        pm_s[k]   <= in_s;
        pm_big[k] <= in_big;
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_add
    logic signed [50:0] sq, r;
    assign sq = pm_neg[k] ? -$signed({2'b00, pm_q[k]}) : $signed({2'b00, pm_q[k]});
    assign r  = sq + PolyCoef[k+1];
    always_ff @(posedge clk) begin
      if (rst) pa_v[k] <= 1'b0;
      else if (adv) pa_v[k] <= pm_v[k];
      if (adv) begin
        pa_mag[k] <= r[50] ? 42'(-r) : 42'(r);
        pa_neg[k] <= r[50];
        pa_s[k]   <= pm_s[k];
        pa_big[k] <= pm_big[k];
      end
    end
  end

  // Corrected lux in Q4
  logic            lx_v;
  logic [LuxW-1:0] lx_val;
  always_ff @(posedge clk) begin
    if (rst) lx_v <= 1'b0;
    else if (adv) lx_v <= pm_v[3];
    if (adv) begin
      if (!pm_big[3]) lx_val <= LuxW'(pm_s[3]);
      else if (pm_neg[3]) lx_val <= '0;
      else lx_val <= LuxW'(pm_q[3][48:16]);
    end
  end

  // Log2 with valid/zero delay line alongside
  logic [5:0]  lg_e;
  logic [11:0] lg_f;
  logic        dl_v [LogLat];
  logic        dl_z [LogLat];

  esc_log2 u_log2 (
    .clk  (clk),
    .en   (adv),
    .x    (lx_val),
    .e    (lg_e),
    .frac (lg_f)
  );

  always_ff @(posedge clk) begin
    if (rst) dl_v[0] <= 1'b0;
    else if (adv) dl_v[0] <= lx_v;
    if (adv) dl_z[0] <= (lx_val == '0);
    for (int i = 1; i < LogLat; i++) begin
      if (rst) dl_v[i] <= 1'b0;
      else if (adv) dl_v[i] <= dl_v[i-1];
      if (adv) dl_z[i] <= dl_z[i-1];
    end
  end

  // EV in Q12, rounded to Q8
  logic signed [19:0] ev_off, ev12;
  logic               ev_v, ev_sat;
  logic signed [15:0] ev8;
  assign ev_off = 20'(IsoLg12[iso_c]) + 20'(CompLg12[comp_c]) - EvOffsetQ12;
  assign ev12   = $signed({2'b00, lg_e, lg_f}) + ev_off + 20'sd8;
  always_ff @(posedge clk) begin
    if (rst) ev_v <= 1'b0;
    else if (adv) ev_v <= dl_v[LogLat-1];
    if (adv) begin
      ev_sat <= dl_z[LogLat-1];
      ev8    <= dl_z[LogLat-1] ? 16'sh8000 : ev12[19:4];
    end
  end

  // Threshold compares
  logic signed [16:0] xs, ys;
  logic [NumAp-2:0]   hits_d, hits;
  logic               cm_v, cm_sat;
  logic signed [15:0] cm_ev;
  assign xs = 17'(ev8) + 17'(ShutLg8[sh_c]);
  assign ys = 17'(FnumSq8[ap_c]) - 17'(ev8);
  always_comb begin
    hits_d = '0;
    if (!cfg_mode) begin
      for (int i = 0; i < NumAp - 1; i++) hits_d[i] = xs > 17'(FnumMid8[i]);
    end else begin
      for (int i = 0; i < NumSh - 1; i++) hits_d[i] = ys > 17'(ShutMid8[i]);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) cm_v <= 1'b0;
    else if (adv) cm_v <= ev_v;
    if (adv) begin
      hits   <= hits_d;
      cm_sat <= ev_sat;
      cm_ev  <= ev8;
    end
  end

  // Output word
  logic [5:0]  cnt;
  logic [15:0] o_ev;
  logic [5:0]  o_ap;
  logic [3:0]  o_sh;
  logic        o_sat;
  assign cnt = 6'($countones(hits));
  always_ff @(posedge clk) begin
    if (rst) o_v <= 1'b0;
    else if (adv) o_v <= cm_v;
    if (adv) begin
      o_ev  <= cm_ev;
      o_sat <= cm_sat;
      o_ap  <= cfg_mode ? ap_c : cnt;
      o_sh  <= cfg_mode ? cnt[3:0] : sh_c;
    end
  end

  assign m_tvalid = o_v;
  assign m_tdata  = {6'd0, o_sh, o_ap, o_ev};
  assign m_tuser  = o_sat;

endmodule
`default_nettype wire

[src/esc_checker.sv]
// Port-level checks for exposure_setting_calculator_core, bound to the top.
// Depends on nothing beyond the top level's ports.
`default_nettype none
module esc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic        m_tuser,
  input wire logic        pready
);

  // Stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed under stall");

  // Input ready tracks output stall
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output");

  // Indices stay inside their tables
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[21:16] <= 6'd37) && (m_tdata[25:22] <= 4'd13))
    else $error("index out of range");

  // Saturation only at the floor value
  a_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[15:0] == 16'h8000)
    else $error("saturated word without floor EV");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind exposure_setting_calculator_core esc_checker u_esc_checker (.*);
`default_nettype wire
